// ----- hdl/cqb_pkg.sv -----
// ---------------------------------------------------------------------------
// cqb_pkg
// types, codes and helpers shared by the clipped quad batcher
// ---------------------------------------------------------------------------
package cqb_pkg;

  localparam logic [2:0] OP_BEGIN = 3'd0;
  localparam logic [2:0] OP_END   = 3'd1;
  localparam logic [2:0] OP_PUSH  = 3'd2;
  localparam logic [2:0] OP_POP   = 3'd3;
  localparam logic [2:0] OP_QUAD  = 3'd4;

  localparam logic [1:0] KIND_VTX = 2'd0;
  localparam logic [1:0] KIND_CMD = 2'd1;
  localparam logic [1:0] KIND_UPD = 2'd2;

  localparam int QBITS = 25;

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_PUSH,
    CLS_POP,
    CLS_QUAD
  } cls_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [23:0] rect_x;
    logic signed [23:0] rect_y;
    logic signed [23:0] rect_w;
    logic signed [23:0] rect_h;
    logic signed [23:0] tex_u0;
    logic signed [23:0] tex_v0;
    logic signed [23:0] tex_u1;
    logic signed [23:0] tex_v1;
    logic [31:0]        color;
    logic [15:0]        texture;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic [31:0]        rgba;
    logic [15:0]        tex_handle;
    logic               clipped;
    logic [23:0]        index_value;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    cls_t  cls;
    item_t item;
  } work_t;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -27'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/cqb_front.sv -----
// ---------------------------------------------------------------------------
// cqb_front
// accepts items, tracks the frame, classifies and queues work for the back end
// ---------------------------------------------------------------------------
module cqb_front import cqb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  output logic  full,
  output logic  q_valid,
  output work_t q_data,
  input  logic  q_pop
);

  logic        frame_active;
  work_t       buf_q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        acc;
  logic        fwd;
  cls_t        cls;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_data  = buf_q[rp];
  assign acc     = push && !full;

  always_comb begin
    fwd = 1'b0;
    cls = CLS_QUAD;
    unique case (item.op)
      OP_BEGIN: begin
        fwd = 1'b1;
        cls = CLS_CLEAR;
      end
      OP_PUSH: begin
        fwd = frame_active;
        cls = CLS_PUSH;
      end
      OP_POP: begin
        fwd = frame_active;
        cls = CLS_POP;
      end
      OP_QUAD: begin
        fwd = frame_active;
        cls = CLS_QUAD;
      end
      default: begin
        fwd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && fwd) begin
      buf_q[wp] <= '{cls: cls, item: item};
    end
    if (rst) begin
      frame_active <= 1'b0;
      wp           <= 1'b0;
      rp           <= 1'b0;
      cnt          <= 2'd0;
    end else begin
      if (acc && item.op == OP_BEGIN) begin
        frame_active <= 1'b1;
      end else if (acc && item.op == OP_END) begin
        frame_active <= 1'b0;
      end
      if (acc && fwd) begin
        wp <= ~wp;
      end
      if (q_pop && q_valid) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, acc && fwd} - {1'b0, q_pop && q_valid};
    end
  end

endmodule

// ----- hdl/cqb_div.sv -----
// ---------------------------------------------------------------------------
// cqb_div
// restoring divider, one quotient bit per cycle, for the uv rescale
// ---------------------------------------------------------------------------
module cqb_div import cqb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [47:0]       num,
  input  logic [23:0]       den,
  output logic              done,
  output logic [QBITS-1:0]  quo
);

  logic             busy;
  logic [4:0]       cnt;
  logic [23:0]      rem;
  logic [QBITS-1:0] low;
  logic [23:0]      dreg;
  logic [24:0]      trial;
  logic             ge;

  assign trial = {rem, low[QBITS-1]};
  assign ge    = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num[47:QBITS]};
      low  <= num[QBITS-1:0];
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? 24'(trial - {1'b0, dreg}) : trial[23:0];
      low <= {low[QBITS-2:0], 1'b0};
      quo <= {quo[QBITS-2:0], ge};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QBITS - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/cqb_back.sv -----
// ---------------------------------------------------------------------------
// cqb_back
// carries out queued work: clip stack, quad clipping, vertex, command and index update output
// ---------------------------------------------------------------------------
module cqb_back import cqb_pkg::*; #(
  parameter int CLIP_DEPTH = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  work_t   q_data,
  output logic    q_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int SPW = $clog2(CLIP_DEPTH + 1);
  localparam int AW  = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_POPRD, S_CMD, S_MUL, S_DIVGO, S_DIVWAIT, S_VTX, S_UPD
  } state_t;

  state_t state;

  logic signed [23:0] cox, coy, csw, csh;
  logic               clip_on;
  logic [SPW-1:0]     sp;
  logic [15:0]        cur_tex;
  logic [15:0]        vcount;
  logic [INDEX_BITS-1:0] icount;
  logic [INDEX_BITS-1:0] coff;
  logic               cmd_open;

  logic [95:0]        stk [CLIP_DEPTH];
  logic [95:0]        stk_rd;
  logic [SPW-1:0]     spm1;
  logic               stk_we;

  logic               cmd_last;
  logic               qclip;
  logic signed [23:0] fx0, fy0, fx1, fy1;
  logic signed [23:0] u0, v0, u1, v1;
  logic signed [24:0] du, dv;
  logic [23:0]        ddx, ddy, ddr, ddb;
  logic signed [23:0] qw, qh;
  logic [31:0]        qrgba;
  logic [1:0]         k;
  logic [1:0]         vi;
  logic signed [49:0] prod;

  logic               ovalid;
  logic               ofree;
  logic               emit;

  logic signed [23:0] rx, ry, rw, rh;
  logic signed [24:0] ex1, ey1, cx1, cy1;
  logic signed [23:0] r0, r1;
  logic signed [24:0] r2, r3;
  logic               hit;
  logic signed [23:0] nox, noy, nsw, nsh;
  logic signed [24:0] ma, mb;
  logic [49:0]        pabs;
  logic [47:0]        dnum;
  logic [23:0]        dden;
  logic               ddone;
  logic [QBITS-1:0]   dquo;
  logic signed [25:0] qs;
  logic [15:0]        vnum;

  function automatic logic [23:0] idx24(input logic [INDEX_BITS-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[23:0];
  endfunction

  assign empty = !ovalid;
  assign ofree = !ovalid || pop;
  assign emit  = ofree && (state == S_CMD || state == S_VTX || state == S_UPD);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign spm1  = sp - SPW'(1);

  always_comb begin
    rx  = q_data.item.rect_x;
    ry  = q_data.item.rect_y;
    rw  = q_data.item.rect_w;
    rh  = q_data.item.rect_h;
    ex1 = 25'(rx) + 25'(rw);
    ey1 = 25'(ry) + 25'(rh);
    cx1 = 25'(cox) + 25'(csw);
    cy1 = 25'(coy) + 25'(csh);
    r0  = (rx > cox) ? rx : cox;
    r1  = (ry > coy) ? ry : coy;
    r2  = (ex1 < cx1) ? ex1 : cx1;
    r3  = (ey1 < cy1) ? ey1 : cy1;
    hit = (r2 > 25'(r0)) && (r3 > 25'(r1));
    if (!clip_on) begin
      nox = rx;
      noy = ry;
      nsw = rw;
      nsh = rh;
    end else if (hit) begin
      nox = r0;
      noy = r1;
      nsw = sat24(27'(r2) - 27'(r0));
      nsh = sat24(27'(r3) - 27'(r1));
    end else begin
      nox = '0;
      noy = '0;
      nsw = '0;
      nsh = '0;
    end
    stk_we = (state == S_IDLE) && q_valid && (q_data.cls == CLS_PUSH)
             && (sp < SPW'(CLIP_DEPTH));
  end

  always_comb begin
    case (k)
      2'd0: begin
        ma = {1'b0, ddx};
        mb = du;
      end
      2'd1: begin
        ma = {1'b0, ddy};
        mb = dv;
      end
      2'd2: begin
        ma = {1'b0, ddr};
        mb = du;
      end
      default: begin
        ma = {1'b0, ddb};
        mb = dv;
      end
    endcase
    dden = k[0] ? qh : qw;
    pabs = prod[49] ? 50'(-prod) : 50'(prod);
    dnum = pabs[47:0] + {25'd0, dden[23:1]};
    qs   = prod[49] ? -{1'b0, dquo} : {1'b0, dquo};
    vnum = vcount + {14'd0, vi};
  end

  cqb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVGO),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[sp[AW-1:0]] <= {cox, coy, csw, csh};
    end
    stk_rd <= stk[spm1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      fx0   <= clip_on ? r0 : rx;
      fy0   <= clip_on ? r1 : ry;
      fx1   <= sat24(27'(clip_on ? r2 : ex1));
      fy1   <= sat24(27'(clip_on ? r3 : ey1));
      u0    <= q_data.item.tex_u0;
      v0    <= q_data.item.tex_v0;
      u1    <= q_data.item.tex_u1;
      v1    <= q_data.item.tex_v1;
      du    <= 25'(q_data.item.tex_u1) - 25'(q_data.item.tex_u0);
      dv    <= 25'(q_data.item.tex_v1) - 25'(q_data.item.tex_v0);
      ddx   <= 24'(25'(r0) - 25'(rx));
      ddy   <= 24'(25'(r1) - 25'(ry));
      ddr   <= 24'(ex1 - r2);
      ddb   <= 24'(ey1 - r3);
      qw    <= rw;
      qh    <= rh;
      qrgba <= q_data.item.color;
      qclip <= clip_on;
    end
    if (state == S_MUL) begin
      prod <= ma * mb;
    end
    if (state == S_DIVWAIT && ddone) begin
      case (k)
        2'd0: u0 <= sat24(27'(u0) + 27'(qs));
        2'd1: v0 <= sat24(27'(v0) + 27'(qs));
        2'd2: u1 <= sat24(27'(u1) - 27'(qs));
        default: v1 <= sat24(27'(v1) - 27'(qs));
      endcase
    end

    if (rst) begin
      state    <= S_IDLE;
      cox      <= '0;
      coy      <= '0;
      csw      <= '0;
      csh      <= '0;
      clip_on  <= 1'b0;
      sp       <= '0;
      cur_tex  <= '0;
      vcount   <= '0;
      icount   <= '0;
      coff     <= '0;
      cmd_open <= 1'b0;
      cmd_last <= 1'b0;
      k        <= '0;
      vi       <= '0;
      ovalid   <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            k  <= '0;
            vi <= '0;
            unique case (q_data.cls)
              CLS_CLEAR: begin
                cox      <= '0;
                coy      <= '0;
                csw      <= '0;
                csh      <= '0;
                clip_on  <= 1'b0;
                sp       <= '0;
                cur_tex  <= '0;
                vcount   <= '0;
                icount   <= '0;
                coff     <= '0;
                cmd_open <= 1'b0;
              end
              CLS_PUSH: begin
                if (sp < SPW'(CLIP_DEPTH)) begin
                  sp <= sp + SPW'(1);
                end
                cox      <= nox;
                coy      <= noy;
                csw      <= nsw;
                csh      <= nsh;
                clip_on  <= 1'b1;
                cmd_last <= 1'b1;
                state    <= S_CMD;
              end
              CLS_POP: begin
                cmd_last <= 1'b1;
                if (sp != '0) begin
                  sp    <= spm1;
                  state <= S_POPRD;
                end else begin
                  clip_on <= 1'b0;
                  state   <= S_CMD;
                end
              end
              CLS_QUAD: begin
                cmd_last <= clip_on && !hit;
                if (q_data.item.texture != cur_tex) begin
                  cur_tex <= q_data.item.texture;
                  state   <= S_CMD;
                end else if (clip_on && !hit) begin
                  state <= S_IDLE;
                end else if (clip_on) begin
                  state <= S_MUL;
                end else begin
                  state <= S_VTX;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_POPRD: begin
          cox     <= stk_rd[95:72];
          coy     <= stk_rd[71:48];
          csw     <= stk_rd[47:24];
          csh     <= stk_rd[23:0];
          clip_on <= (sp != '0) || ($signed(stk_rd[47:24]) > 24'sd0
                     && $signed(stk_rd[23:0]) > 24'sd0);
          state   <= S_CMD;
        end
        S_CMD: begin
          if (ofree) begin
            result   <= '{kind: KIND_CMD, pos_x: cox, pos_y: coy, tex_u: csw,
                          tex_v: csh, rgba: '0, tex_handle: cur_tex,
                          clipped: clip_on, index_value: idx24(icount),
                          last_of_run: cmd_last};
            coff     <= icount;
            cmd_open <= 1'b1;
            if (cmd_last) begin
              state <= S_IDLE;
            end else if (qclip) begin
              state <= S_MUL;
            end else begin
              state <= S_VTX;
            end
          end
        end
        S_MUL: begin
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (ddone) begin
            k <= k + 2'd1;
            state <= (k == 2'd3) ? S_VTX : S_MUL;
          end
        end
        S_VTX: begin
          if (ofree) begin
            result <= '{kind: KIND_VTX,
                        pos_x: (vi == 2'd0 || vi == 2'd3) ? fx0 : fx1,
                        pos_y: vi[1] ? fy1 : fy0,
                        tex_u: (vi == 2'd0 || vi == 2'd3) ? u0 : u1,
                        tex_v: vi[1] ? v1 : v0,
                        rgba: qrgba, tex_handle: '0, clipped: 1'b0,
                        index_value: {8'd0, vnum},
                        last_of_run: (vi == 2'd3) && !cmd_open};
            vi <= vi + 2'd1;
            if (vi == 2'd3) begin
              vcount <= vcount + 16'd4;
              icount <= icount + INDEX_BITS'(6);
              state  <= cmd_open ? S_UPD : S_IDLE;
            end
          end
        end
        S_UPD: begin
          if (ofree) begin
            result <= '{kind: KIND_UPD, pos_x: '0, pos_y: '0, tex_u: '0,
                        tex_v: '0, rgba: '0, tex_handle: '0, clipped: 1'b0,
                        index_value: idx24(icount - coff), last_of_run: 1'b1};
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/clipped_quad_batcher.sv -----
// ---------------------------------------------------------------------------
// clipped_quad_batcher
// 2d draw front end with clip stack, quad scissoring and uv rescale
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        item   (item_t)
//  result    pop / empty        result (result_t)
//
// end and ignored items are dropped in the front with no result, as are
// push, pop and quad outside a frame; begin clears the back end state
// with no result. a clipped quad adds four serial divisions for the uv
// rescale, each a multiply, a start, 25 quotient bits and done.
// rst is synchronous; a two-entry queue lets the front accept while the
// back end stalls on a waiting result until pop
module clipped_quad_batcher import cqb_pkg::*; #(
  parameter int CLIP_DEPTH = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   item,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic  q_valid;
  work_t q_data;
  logic  q_pop;

  cqb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  cqb_back #(
    .CLIP_DEPTH (CLIP_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ----- hdl/cqb_checker.sv -----
// ---------------------------------------------------------------------------
// cqb_checker
// port-level checks for the clipped quad batcher
// ---------------------------------------------------------------------------
module cqb_checker import cqb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  a_reset: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed before transfer");

  a_upd_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_UPD |-> result.last_of_run)
    else $error("index update not last of its run");

  a_vtx_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_VTX |-> result.tex_handle == '0 && !result.clipped)
    else $error("vertex carries command fields");

endmodule

bind clipped_quad_batcher cqb_checker u_cqb_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ----- bench/clipped_quad_batcher_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_quad_batcher_checker
// watches both channels of the quad batcher, predicts the results of every
// accepted item and compares them in order with the results taken
// ---------------------------------------------------------------------------
module clipped_quad_batcher_checker import cqb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  item_t   item,
  input  logic    pop,
  input  logic    empty,
  input  result_t result,
  output int      errors,
  output int      outstanding
);

  localparam int STACK_DEPTH = 16;
  localparam longint IDX_MASK = (64'd1 << 24) - 1;

  result_t expected_results[$];

  logic   in_frame;
  logic   scissor_on;
  longint scissor_x, scissor_y, scissor_w, scissor_h;
  longint saved_x[STACK_DEPTH], saved_y[STACK_DEPTH];
  longint saved_w[STACK_DEPTH], saved_h[STACK_DEPTH];
  int     depth;
  logic [15:0] cur_tex;
  logic [15:0] vtx_num;
  longint idx_total, cmd_base;
  logic   cmd_live;

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic result_t vertex_out(longint x, longint y, longint u, longint v,
                                         logic [31:0] col, logic [15:0] n);
    result_t r;
    r = '0;
    r.kind = KIND_VTX;
    r.pos_x = x[23:0];
    r.pos_y = y[23:0];
    r.tex_u = u[23:0];
    r.tex_v = v[23:0];
    r.rgba = col;
    r.index_value = {8'd0, n};
    return r;
  endfunction

  task automatic clear_state();
    in_frame = 1'b0;
    scissor_on = 1'b0;
    scissor_x = 0; scissor_y = 0; scissor_w = 0; scissor_h = 0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      saved_x[i] = 0; saved_y[i] = 0; saved_w[i] = 0; saved_h[i] = 0;
    end
    depth = 0;
    cur_tex = '0;
    vtx_num = '0;
    idx_total = 0;
    cmd_base = 0;
    cmd_live = 1'b0;
  endtask

  task automatic open_command(ref result_t run[$]);
    result_t r;
    r = '0;
    r.kind = KIND_CMD;
    r.pos_x = scissor_x[23:0];
    r.pos_y = scissor_y[23:0];
    r.tex_u = scissor_w[23:0];
    r.tex_v = scissor_h[23:0];
    r.tex_handle = cur_tex;
    r.clipped = scissor_on;
    r.index_value = idx_total[23:0];
    run = {run, r};
    cmd_base = idx_total;
    cmd_live = 1'b1;
  endtask

  task automatic predict_item(item_t it);
    result_t run[$];
    result_t r;
    longint rx, ry, rw, rh, x0, y0, x1, y1, u0, v0, u1, v1, du, dv;
    longint ix0, iy0, ix1, iy1;
    logic draw;
    rx = longint'(it.rect_x); ry = longint'(it.rect_y);
    rw = longint'(it.rect_w); rh = longint'(it.rect_h);
    if (it.op == OP_BEGIN) begin
      clear_state();
      in_frame = 1'b1;
    end else if (in_frame) begin
      case (it.op)
        OP_END: begin
          in_frame = 1'b0;
        end
        OP_PUSH: begin
          if (scissor_on) begin
            ix0 = (scissor_x > rx) ? scissor_x : rx;
            iy0 = (scissor_y > ry) ? scissor_y : ry;
            ix1 = (scissor_x + scissor_w < rx + rw) ? scissor_x + scissor_w : rx + rw;
            iy1 = (scissor_y + scissor_h < ry + rh) ? scissor_y + scissor_h : ry + rh;
            if (ix1 > ix0 && iy1 > iy0) begin
              x0 = ix0; y0 = iy0; x1 = clamp24(ix1 - ix0); y1 = clamp24(iy1 - iy0);
            end else begin
              x0 = 0; y0 = 0; x1 = 0; y1 = 0;
            end
          end else begin
            x0 = rx; y0 = ry; x1 = rw; y1 = rh;
          end
          if (depth < STACK_DEPTH) begin
            saved_x[depth] = scissor_x; saved_y[depth] = scissor_y;
            saved_w[depth] = scissor_w; saved_h[depth] = scissor_h;
            depth++;
          end
          scissor_x = x0; scissor_y = y0; scissor_w = x1; scissor_h = y1;
          scissor_on = 1'b1;
          open_command(run);
        end
        OP_POP: begin
          if (depth > 0) begin
            depth--;
            scissor_x = saved_x[depth]; scissor_y = saved_y[depth];
            scissor_w = saved_w[depth]; scissor_h = saved_h[depth];
            scissor_on = (depth > 0) || (scissor_w > 0 && scissor_h > 0);
          end else begin
            scissor_on = 1'b0;
          end
          open_command(run);
        end
        OP_QUAD: begin
          u0 = longint'(it.tex_u0); v0 = longint'(it.tex_v0);
          u1 = longint'(it.tex_u1); v1 = longint'(it.tex_v1);
          x0 = rx; y0 = ry; x1 = rx + rw; y1 = ry + rh;
          draw = 1'b1;
          if (it.texture != cur_tex) begin
            cur_tex = it.texture;
            open_command(run);
          end
          if (scissor_on) begin
            ix0 = (x0 > scissor_x) ? x0 : scissor_x;
            iy0 = (y0 > scissor_y) ? y0 : scissor_y;
            ix1 = (x1 < scissor_x + scissor_w) ? x1 : scissor_x + scissor_w;
            iy1 = (y1 < scissor_y + scissor_h) ? y1 : scissor_y + scissor_h;
            if (!(ix1 > ix0 && iy1 > iy0)) begin
              draw = 1'b0;
            end else begin
              du = u1 - u0;
              dv = v1 - v0;
              u0 = clamp24(u0 + round_div((ix0 - x0) * du, rw));
              v0 = clamp24(v0 + round_div((iy0 - y0) * dv, rh));
              u1 = clamp24(u1 - round_div((x1 - ix1) * du, rw));
              v1 = clamp24(v1 - round_div((y1 - iy1) * dv, rh));
              x0 = ix0; y0 = iy0; x1 = ix1; y1 = iy1;
            end
          end
          if (draw) begin
            x1 = clamp24(x1);
            y1 = clamp24(y1);
            run = {run, vertex_out(x0, y0, u0, v0, it.color, vtx_num)};
            run = {run, vertex_out(x1, y0, u1, v0, it.color, vtx_num + 16'd1)};
            run = {run, vertex_out(x1, y1, u1, v1, it.color, vtx_num + 16'd2)};
            run = {run, vertex_out(x0, y1, u0, v1, it.color, vtx_num + 16'd3)};
            vtx_num = vtx_num + 16'd4;
            idx_total = (idx_total + 6) & IDX_MASK;
            if (cmd_live) begin
              r = '0;
              r.kind = KIND_UPD;
              r.index_value = 24'((idx_total - cmd_base) & IDX_MASK);
              run = {run, r};
            end
          end
        end
        default: ;
      endcase
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) expected_results = {expected_results, run[i]};
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no expected transfer waiting: %h", got);
      errors++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", longint'(want.kind), longint'(got.kind));
      check_field("pos_x", longint'(want.pos_x), longint'(got.pos_x));
      check_field("pos_y", longint'(want.pos_y), longint'(got.pos_y));
      check_field("tex_u", longint'(want.tex_u), longint'(got.tex_u));
      check_field("tex_v", longint'(want.tex_v), longint'(got.tex_v));
      check_field("rgba", longint'(want.rgba), longint'(got.rgba));
      check_field("tex_handle", longint'(want.tex_handle), longint'(got.tex_handle));
      check_field("clipped", longint'(want.clipped), longint'(got.clipped));
      check_field("index_value", longint'(want.index_value), longint'(got.index_value));
      check_field("last_of_run", longint'(want.last_of_run), longint'(got.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      errors = 0;
    end else begin
      if (pop && !empty) check_result(result);
      if (push && !full) predict_item(item);
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- bench/clipped_quad_batcher_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_quad_batcher_tb
// directed and random draw streams with random idling on both sides; the
// checker beside the block predicts and compares every result transfer
// ---------------------------------------------------------------------------
module clipped_quad_batcher_tb;
  import cqb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic    clk;
  logic    rst;
  logic    push;
  item_t   item;
  logic    full;
  logic    empty;
  logic    pop;
  result_t result;
  int      errors;
  int      outstanding;
  int      phase;
  int      stall_cycles;

  clipped_quad_batcher dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .empty(empty), .pop(pop), .result(result)
  );

  clipped_quad_batcher_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic item_t mk(logic [2:0] op, int x, int y, int w, int h,
                               int u0, int v0, int u1, int v1,
                               logic [31:0] col, logic [15:0] tex);
    item_t it;
    it.op = op;
    it.rect_x = x[23:0]; it.rect_y = y[23:0];
    it.rect_w = w[23:0]; it.rect_h = h[23:0];
    it.tex_u0 = u0[23:0]; it.tex_v0 = v0[23:0];
    it.tex_u1 = u1[23:0]; it.tex_v1 = v1[23:0];
    it.color = col;
    it.texture = tex;
    return it;
  endfunction

  function automatic int coord();
    return int'($urandom_range(6000)) - 2000;
  endfunction

  function automatic int extent();
    if ($urandom_range(9) == 0) return int'($urandom_range(600)) - 300;
    return int'($urandom_range(3000));
  endfunction

  function automatic item_t random_item(logic [2:0] op);
    item_t it;
    logic [15:0] tex;
    case ($urandom_range(3))
      0: tex = 16'd0;
      1: tex = 16'd1;
      2: tex = 16'd2;
      default: tex = 16'($urandom);
    endcase
    it = mk(op, coord(), coord(), extent(), extent(),
            $urandom, $urandom, $urandom, $urandom, $urandom, tex);
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  task automatic send(item_t it);
    int idle_pct;
    idle_pct = (phase == 1) ? 55 : (phase == 3) ? 19 : 0;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // receiver: random stalls per phase, one long hold when the stall phase starts
  initial begin
    int prev_phase;
    int stall_pct;
    prev_phase = 0;
    stall_cycles = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && prev_phase != 2) stall_cycles = LONG_HOLD;
      prev_phase = phase;
      stall_pct = (phase == 2) ? 55 : (phase == 3) ? 19 : 0;
      if (stall_cycles > 0) begin
        stall_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || rst) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int pick;
    phase = 0;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed
    send(mk(OP_QUAD, 0, 0, 256, 256, 0, 0, 65536, 65536, 32'hffffffff, 16'd0));
    send(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_QUAD, 0, 0, 256, 256, 0, 0, 65536, 65536, 32'h11223344, 16'd0));
    send(mk(OP_QUAD, 100, 200, 300, 400, 0, 0, 65536, 65536, 32'h0, 16'd7));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd7));
    send(mk(OP_PUSH, 0, 0, 1000, 1000, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_QUAD, -500, -500, 1000, 3000, -65536, 0, 65536, 131072,
            32'hdeadbeef, 16'd7));
    send(mk(OP_QUAD, 2000, 2000, 100, 100, 0, 0, 65536, 65536, 32'h1, 16'd7));
    send(mk(OP_PUSH, 5000, 5000, 100, 100, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_PUSH, -8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_PUSH, -8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_PUSH, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_QUAD, 8388607, 8388607, 8388607, 8388607, 8388607, -8388608,
            -8388608, 8388607, 32'hffffffff, 16'hffff));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_QUAD, 0, 0, 256, 256, 0, 0, 0, 0, 32'h5, 16'd3));
    send(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));

    // random, four idling phases
    for (phase = 0; phase < 4; phase++) begin
      sent = 0;
      if (phase == 0) begin
        // stack overflow burst
        for (int i = 0; i < 18; i++) send(random_item(OP_PUSH));
        send(random_item(OP_QUAD));
        for (int i = 0; i < 18; i++) send(random_item(OP_POP));
        sent += 37;
      end
      while (sent < 84) begin
        pick = $urandom_range(99);
        if (pick < 55) send(random_item(OP_QUAD));
        else if (pick < 70) send(random_item(OP_PUSH));
        else if (pick < 82) send(random_item(OP_POP));
        else if (pick < 85) send(random_item(OP_END));
        else if (pick < 88) send(random_item(OP_BEGIN));
        else if (pick < 92) begin
          send(random_item(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO))));
          continue;
        end else send(noise_item());
        sent++;
      end
    end
    push <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
